>>> rtl/mbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_pkg
// Types, constants and request frame tables of the battery poller.
// ----------------------------------------------------------------------------
package mbp_pkg;

   localparam int Q_DEPTH_DEFAULT = 4;

   localparam int HDR_DEPTH = 7;
   localparam int HDR_IDX_W = 3;
   localparam int LEN_W     = 4;
   localparam int FRAME_LEN = 8;
   localparam int BIDX_W    = 3;

   localparam logic [LEN_W-1:0]  LEN_MAX     = 4'd15;
   localparam logic [LEN_W-1:0]  LEN_MIN     = 4'd5;
   localparam logic [LEN_W-1:0]  LEN_SOC     = 4'd7;
   localparam logic [LEN_W-1:0]  LEN_PWR     = 4'd9;
   localparam logic [BIDX_W-1:0] BIDX_LAST   = 3'(FRAME_LEN - 1);

   localparam logic [7:0] SLAVE_ID    = 8'h01;
   localparam logic [7:0] FUNC_READ   = 8'h03;
   localparam logic [7:0] BCNT_PWR    = 8'h04;
   localparam logic [7:0] BCNT_SOC    = 8'h02;
   localparam logic [7:0] REG_SOC     = 8'h28;
   localparam logic [7:0] CNT_SOC     = 8'h01;
   localparam logic [7:0] REG_PWR     = 8'h13;
   localparam logic [7:0] CNT_PWR     = 8'h02;

   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;

   localparam logic [7:0]  SOC_RESET       = 8'd100;
   localparam logic [6:0]  THRESHOLD_RESET = 7'd20;
   localparam logic [14:0] HALF_RESET      = 15'd1000;

   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_HALF      = 1'b1;

   localparam logic [1:0] OP_STATUS  = 2'd0;
   localparam logic [1:0] OP_REQ_SOC = 2'd1;
   localparam logic [1:0] OP_REQ_PWR = 2'd2;

   typedef struct packed {
      logic [6:0]  threshold;
      logic [14:0] half_period;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [7:0]         soc;
      logic signed [15:0] current;
      logic [15:0]        capacity;
   } entry_type;

   // CRC-16/MODBUS over six bytes, first byte in the top bits
   function automatic logic [15:0] crc16_6(input logic [47:0] frame);
      logic [15:0] crc;
      crc = CRC_INIT;
      for (int i = 5; i >= 0; i--) begin
         crc = crc ^ {8'h00, frame[i*8 +: 8]};
         for (int b = 0; b < 8; b++) begin
            crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
         end
      end
      return crc;
   endfunction

   localparam logic [47:0] HEAD_SOC =
      {SLAVE_ID, FUNC_READ, 8'h00, REG_SOC, 8'h00, CNT_SOC};
   localparam logic [47:0] HEAD_PWR =
      {SLAVE_ID, FUNC_READ, 8'h00, REG_PWR, 8'h00, CNT_PWR};
   localparam logic [15:0] CRC_SOC = crc16_6(HEAD_SOC);
   localparam logic [15:0] CRC_PWR = crc16_6(HEAD_PWR);
   localparam logic [63:0] FRAME_SOC = {HEAD_SOC, CRC_SOC[7:0], CRC_SOC[15:8]};
   localparam logic [63:0] FRAME_PWR = {HEAD_PWR, CRC_PWR[7:0], CRC_PWR[15:8]};

   function automatic logic [7:0] req_byte(input logic [1:0] op,
                                           input logic [BIDX_W-1:0] idx);
      logic [63:0] frame;
      frame = (op == OP_REQ_SOC) ? FRAME_SOC : FRAME_PWR;
      return frame[(BIDX_LAST - idx)*8 +: 8];
   endfunction

endpackage
`default_nettype wire

>>> rtl/mbp_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_ifs
// Channel interfaces: request words, response words, register writes.
// ----------------------------------------------------------------------------
interface mbp_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] rx_byte;
   logic       rx_last;
   modport source(output valid, kind, rx_byte, rx_last, input ready);
   modport sink(input valid, kind, rx_byte, rx_last, output ready);
endinterface

interface mbp_rsp_if;
   logic               valid;
   logic               ready;
   logic               tx_valid;
   logic [7:0]         tx_byte;
   logic               tx_last;
   logic [7:0]         soc_percent;
   logic signed [15:0] current_centiamps;
   logic [15:0]        capacity_centiamphours;
   logic               need_charge;
   logic               charging;
   modport source(output valid, tx_valid, tx_byte, tx_last, soc_percent,
                  current_centiamps, capacity_centiamphours, need_charge,
                  charging, input ready);
   modport sink(input valid, tx_valid, tx_byte, tx_last, soc_percent,
                current_centiamps, capacity_centiamphours, need_charge,
                charging, output ready);
endinterface

interface mbp_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [14:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/mbp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_front
// Takes ticks and received bytes, runs the poll counter and frame parser,
// and queues one command per word with a status snapshot.
// ----------------------------------------------------------------------------
module mbp_front
   import mbp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   mbp_req_if.sink   req,
   input  cfg_type   cfg,
   input  logic      q_full,
   output logic      q_push,
   output entry_type q_entry
);

   logic [15:0]        tick_ff, tick_in;
   logic [LEN_W-1:0]   len_ff, len_in, len_inc;
   logic [7:0]         soc_ff, soc_in;
   logic signed [15:0] cur_ff, cur_in;
   logic [15:0]        cap_ff, cap_in;
   logic [7:0]         hdr_ff [HDR_DEPTH];
   logic [7:0]         hv [HDR_DEPTH];
   logic [15:0]        tick_inc;
   logic [1:0]         op;
   logic               accept;
   logic               head_ok;

   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;
   assign q_push    = accept;

   assign tick_inc = tick_ff + 16'd1;
   assign len_inc  = (len_ff == LEN_MAX) ? LEN_MAX : len_ff + 4'd1;

   // header as it stands with this byte written
   always_comb begin
      for (int i = 0; i < HDR_DEPTH; i++) begin
         hv[i] = (len_ff == LEN_W'(i)) ? req.rx_byte : hdr_ff[i];
      end
   end

   assign head_ok = (len_inc >= LEN_MIN) && (hv[0] == SLAVE_ID) && (hv[1] == FUNC_READ);

   always_comb begin
      tick_in = tick_ff;
      len_in  = len_ff;
      soc_in  = soc_ff;
      cur_in  = cur_ff;
      cap_in  = cap_ff;
      op      = OP_STATUS;
      if (!req.kind) begin
         tick_in = tick_inc;
         priority if (tick_inc == {1'b0, cfg.half_period}) begin
            op = OP_REQ_SOC;
         end else if (tick_inc == {cfg.half_period, 1'b0}) begin
            op      = OP_REQ_PWR;
            tick_in = '0;
         end
      end else begin
         len_in = len_inc;
         if (req.rx_last) begin
            len_in = '0;
            priority if (head_ok && len_inc >= LEN_PWR && hv[2] == BCNT_PWR) begin
               cur_in = {hv[3], hv[4]};
               cap_in = {hv[5], hv[6]};
            end else if (head_ok && len_inc >= LEN_SOC && hv[2] == BCNT_SOC) begin
               soc_in = hv[4];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
         len_ff  <= '0;
         soc_ff  <= SOC_RESET;
         cur_ff  <= '0;
         cap_ff  <= '0;
      end else if (accept) begin
         tick_ff <= tick_in;
         len_ff  <= len_in;
         soc_ff  <= soc_in;
         cur_ff  <= cur_in;
         cap_ff  <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req.kind && len_ff < LEN_W'(HDR_DEPTH)) begin
         hdr_ff[len_ff[HDR_IDX_W-1:0]] <= req.rx_byte;
      end
   end

   always_comb begin
      q_entry.op       = op;
      q_entry.soc      = soc_in;
      q_entry.current  = cur_in;
      q_entry.capacity = cap_in;
   end

endmodule
`default_nettype wire

>>> rtl/mbp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_queue
// Small command FIFO between front and back.
// ----------------------------------------------------------------------------
module mbp_queue
   import mbp_pkg::*;
#(
   parameter int Depth = Q_DEPTH_DEFAULT
)(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head_entry
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

   entry_type         mem_ff [Depth];
   logic [PtrW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full       = (cnt_ff == CntW'(Depth));
   assign head_valid = (cnt_ff != '0);
   assign head_entry = mem_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PtrLast) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PtrLast) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

>>> rtl/mbp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_back
// Expands queued commands into response words: eight request bytes or one
// status word, held in an output register.
// ----------------------------------------------------------------------------
module mbp_back
   import mbp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      head_valid,
   input  entry_type head_entry,
   output logic      pop,
   mbp_rsp_if.source rsp
);

   logic               valid_ff;
   logic [BIDX_W-1:0]  bidx_ff;
   logic               txv_ff, txl_ff, need_ff, chg_ff;
   logic [7:0]         txb_ff, soc_ff;
   logic signed [15:0] cur_ff;
   logic [15:0]        cap_ff;
   logic               load, is_req, last;

   assign load   = head_valid && (!valid_ff || rsp.ready);
   assign is_req = (head_entry.op != OP_STATUS);
   assign last   = !is_req || (bidx_ff == BIDX_LAST);
   assign pop    = load && last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         bidx_ff  <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         bidx_ff  <= last ? '0 : bidx_ff + 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         txv_ff  <= is_req;
         txb_ff  <= is_req ? req_byte(head_entry.op, bidx_ff) : 8'h00;
         txl_ff  <= last;
         soc_ff  <= head_entry.soc;
         cur_ff  <= head_entry.current;
         cap_ff  <= head_entry.capacity;
         need_ff <= (head_entry.soc < {1'b0, cfg.threshold});
         chg_ff  <= !head_entry.current[15] && (head_entry.current != '0);
      end
   end

   assign rsp.valid                  = valid_ff;
   assign rsp.tx_valid               = txv_ff;
   assign rsp.tx_byte                = txb_ff;
   assign rsp.tx_last                = txl_ff;
   assign rsp.soc_percent            = soc_ff;
   assign rsp.current_centiamps      = cur_ff;
   assign rsp.capacity_centiamphours = cap_ff;
   assign rsp.need_charge            = need_ff;
   assign rsp.charging               = chg_ff;

endmodule
`default_nettype wire

>>> rtl/modbus_battery_poller_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_battery_poller_unit
// Modbus RTU poller for a battery monitor: alternating read requests with
// CRC-16, response frame parsing, SOC/current/capacity status.
// ----------------------------------------------------------------------------
//  channel | dir | words
//  req_bus | in  | kind, rx_byte, rx_last
//  rsp_bus | out | tx_valid, tx_byte, tx_last, status fields
//  csr_bus | in  | index, data (0 threshold, 1 half period)
//
//  A tick or byte is taken while the command queue has room.
//  Each word yields one response word; a poll tick yields eight, counted by
//  the back end's byte counter, one per cycle while rsp_bus is ready.
//  The queue (QueueDepth entries) and the output register decouple stalls.
//  Synchronous reset clears counters, queue and status (SOC to 100).
// ----------------------------------------------------------------------------
module modbus_battery_poller_unit
   import mbp_pkg::*;
#(
   parameter int QueueDepth = Q_DEPTH_DEFAULT
)(
   input  logic      clock,
   input  logic      reset,
   mbp_req_if.sink   req_bus,
   mbp_rsp_if.source rsp_bus,
   mbp_csr_if.sink   csr_bus
);

   cfg_type   cfg_ff;
   logic      q_full, q_push, q_pop, q_valid;
   entry_type q_in, q_head;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold   <= THRESHOLD_RESET;
         cfg_ff.half_period <= HALF_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_THRESHOLD: cfg_ff.threshold   <= csr_bus.data[6:0];
            CSR_HALF:      cfg_ff.half_period <= csr_bus.data;
            default: ;
         endcase
      end
   end

   mbp_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .cfg     (cfg_ff),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_entry (q_in)
   );

   mbp_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (q_head)
   );

   mbp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (q_valid),
      .head_entry (q_head),
      .pop        (q_pop),
      .rsp        (rsp_bus)
   );

endmodule
`default_nettype wire

>>> dv/modbus_battery_poller_unit_test.sv
// ----------------------------------------------------------------------------
// modbus_battery_poller_unit_test
// Self-checking bench for the battery poller. Ticks and received bytes go in
// on the request channel in random bursts; response words are taken under a
// stall pattern. A scoreboard predicts every response word (request frames
// with CRC-16, parsed SOC/current/capacity and the status flags) and checks
// each one field by field. Covers directed cases, well-formed and broken
// frames under several register settings, and a half period lowered below
// the running count.
// ----------------------------------------------------------------------------

typedef struct {
   logic        tx_valid;
   logic [7:0]  tx_byte;
   logic        tx_last;
   logic [7:0]  soc;
   logic [15:0] current;
   logic [15:0] capacity;
   logic        need_charge;
   logic        charging;
} poll_word_type;

class poller_scoreboard;
   bit [6:0]   threshold;
   bit [14:0]  half_period;
   bit [15:0]  tick_count;
   bit [7:0]   rx_header[7];
   bit [3:0]   rx_length;
   bit [7:0]   soc;
   bit [15:0]  current;
   bit [15:0]  capacity;
   poll_word_type expected_words[$];
   int         errors;

   function new();
      threshold   = mbp_pkg::THRESHOLD_RESET;
      half_period = mbp_pkg::HALF_RESET;
      soc         = mbp_pkg::SOC_RESET;
      tick_count  = '0;
      rx_length   = '0;
      current     = '0;
      capacity    = '0;
      errors      = 0;
   endfunction

   function void write_reg(bit idx, bit [14:0] data);
      if (idx == mbp_pkg::CSR_THRESHOLD) begin
         threshold = data[6:0];
      end else begin
         half_period = data;
      end
   endfunction

   function poll_word_type status_word(bit tx_valid, bit [7:0] tx_byte, bit tx_last);
      poll_word_type w;
      w.tx_valid    = tx_valid;
      w.tx_byte     = tx_byte;
      w.tx_last     = tx_last;
      w.soc         = soc;
      w.current     = current;
      w.capacity    = capacity;
      w.need_charge = soc < {1'b0, threshold};
      w.charging    = !current[15] && current != 16'd0;
      return w;
   endfunction

   // 01 03 00 reg 00 cnt, CRC low then high
   function void queue_request(bit [7:0] reg_addr, bit [7:0] reg_count);
      bit [7:0]  frame[8];
      bit [15:0] crc;
      bit        fb;
      frame[0] = mbp_pkg::SLAVE_ID;
      frame[1] = mbp_pkg::FUNC_READ;
      frame[2] = 8'h00;
      frame[3] = reg_addr;
      frame[4] = 8'h00;
      frame[5] = reg_count;
      crc = mbp_pkg::CRC_INIT;
      for (int i = 0; i < 6; i++) begin
         for (int k = 0; k < 8; k++) begin
            fb  = crc[0] ^ frame[i][k];
            crc = crc >> 1;
            if (fb) begin
               crc = crc ^ mbp_pkg::CRC_POLY;
            end
         end
      end
      frame[6] = crc[7:0];
      frame[7] = crc[15:8];
      for (int i = 0; i < 8; i++) begin
         expected_words.push_back(status_word(1'b1, frame[i], i == 7));
      end
   endfunction

   function void note_input(bit kind, bit [7:0] rx_byte, bit rx_last);
      bit [15:0] full;
      if (!kind) begin
         full = {half_period, 1'b0};
         tick_count++;
         if (tick_count == {1'b0, half_period}) begin
            queue_request(mbp_pkg::REG_SOC, mbp_pkg::CNT_SOC);
            return;
         end
         if (tick_count == full) begin
            tick_count = '0;
            queue_request(mbp_pkg::REG_PWR, mbp_pkg::CNT_PWR);
            return;
         end
      end else begin
         if (rx_length < mbp_pkg::HDR_DEPTH) begin
            rx_header[rx_length] = rx_byte;
         end
         if (rx_length != mbp_pkg::LEN_MAX) begin
            rx_length++;
         end
         if (rx_last) begin
            if (rx_length >= mbp_pkg::LEN_MIN && rx_header[0] == mbp_pkg::SLAVE_ID &&
                rx_header[1] == mbp_pkg::FUNC_READ) begin
               if (rx_length >= mbp_pkg::LEN_PWR && rx_header[2] == mbp_pkg::BCNT_PWR) begin
                  current  = {rx_header[3], rx_header[4]};
                  capacity = {rx_header[5], rx_header[6]};
               end else if (rx_length >= mbp_pkg::LEN_SOC &&
                            rx_header[2] == mbp_pkg::BCNT_SOC) begin
                  soc = rx_header[4];
               end
            end
            rx_length = '0;
         end
      end
      expected_words.push_back(status_word(1'b0, 8'h00, 1'b1));
   endfunction

   function void check_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endfunction

   function void check_word(poll_word_type got);
      poll_word_type want;
      if (expected_words.size() == 0) begin
         errors++;
         $display("%0t: response word with nothing outstanding, expected none, actual %0h",
                  $time, got.tx_byte);
         return;
      end
      want = expected_words.pop_front();
      check_field("tx_valid", want.tx_valid, got.tx_valid);
      check_field("tx_byte", want.tx_byte, got.tx_byte);
      check_field("tx_last", want.tx_last, got.tx_last);
      check_field("soc_percent", want.soc, got.soc);
      check_field("current_centiamps", want.current, got.current);
      check_field("capacity_centiamphours", want.capacity, got.capacity);
      check_field("need_charge", want.need_charge, got.need_charge);
      check_field("charging", want.charging, got.charging);
   endfunction
endclass

module modbus_battery_poller_unit_test;
   import mbp_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mbp_req_if req_bus();
   mbp_rsp_if rsp_bus();
   mbp_csr_if csr_bus();

   modbus_battery_poller_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   poller_scoreboard sb;
   int       idle_cycles = 0;
   int       items_sent = 0;
   int       burst_left = 0;
   int       gap_max = 0;
   int       stall_level = 0;
   int       ready_run = 0;
   logic     ready_level = 1'b1;
   bit [7:0] frame_q[$];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver: ready/stall runs, lengths set by stall_level; level 0 never stalls
   always @(negedge clock) begin
      if (ready_run == 0) begin
         if (stall_level == 0) begin
            ready_level = 1'b1;
            ready_run   = 8;
         end else if (ready_level) begin
            ready_level = 1'b0;
            ready_run   = $urandom_range(1, stall_level == 1 ? 2 : 6);
         end else begin
            ready_level = 1'b1;
            ready_run   = $urandom_range(1, stall_level == 1 ? 12 : 4);
         end
      end
      ready_run--;
      rsp_bus.ready <= ready_level;
   end

   always @(posedge clock) begin
      poll_word_type got;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) begin
            sb.write_reg(csr_bus.index, csr_bus.data);
         end
         if (req_bus.valid && req_bus.ready) begin
            sb.note_input(req_bus.kind, req_bus.rx_byte, req_bus.rx_last);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.tx_valid    = rsp_bus.tx_valid;
            got.tx_byte     = rsp_bus.tx_byte;
            got.tx_last     = rsp_bus.tx_last;
            got.soc         = rsp_bus.soc_percent;
            got.current     = rsp_bus.current_centiamps;
            got.capacity    = rsp_bus.capacity_centiamphours;
            got.need_charge = rsp_bus.need_charge;
            got.charging    = rsp_bus.charging;
            sb.check_word(got);
         end
         if ((csr_bus.valid && csr_bus.ready) || (req_bus.valid && req_bus.ready) ||
             (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
               $display("Simulation FAILED");
               $finish;
            end
         end
      end
   end

   function automatic bit [7:0] pick_byte();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void load_frame(logic [71:0] bytes, int n);
      frame_q.delete();
      for (int i = 0; i < n; i++) begin
         frame_q.push_back(bytes[(n - 1 - i) * 8 +: 8]);
      end
   endfunction

   function automatic void break_frame();
      int n;
      case ($urandom_range(0, 4))
         0: frame_q[0] = frame_q[0] ^ (8'h01 << $urandom_range(0, 7));
         1: frame_q[1] = frame_q[1] ^ (8'h01 << $urandom_range(0, 7));
         2: frame_q[2] = frame_q[2] ^ (8'h01 << $urandom_range(0, 7));
         3: begin
            n = $urandom_range(1, frame_q.size() - 1);
            frame_q = frame_q[0:n-1];
         end
         default: begin
            frame_q.delete();
            repeat ($urandom_range(1, 20)) frame_q.push_back(8'($urandom));
         end
      endcase
   endfunction

   task automatic pace();
      if (gap_max > 0) begin
         if (burst_left == 0) begin
            repeat ($urandom_range(1, gap_max)) begin
               @(negedge clock);
               req_bus.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 16);
         end
         burst_left--;
      end
   endtask

   task automatic send_word(bit kind, bit [7:0] rx_byte, bit rx_last);
      pace();
      @(negedge clock);
      req_bus.valid   <= 1'b1;
      req_bus.kind    <= kind;
      req_bus.rx_byte <= rx_byte;
      req_bus.rx_last <= rx_last;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   // ticks carry junk in the byte fields
   task automatic send_tick();
      send_word(1'b0, 8'($urandom), 1'($urandom));
   endtask

   task automatic send_ticks(int n);
      repeat (n) send_tick();
   endtask

   task automatic send_frame(int tick_pct);
      foreach (frame_q[i]) begin
         if ($urandom_range(0, 99) < tick_pct) begin
            send_tick();
         end
         send_word(1'b1, frame_q[i], i == frame_q.size() - 1);
      end
   endtask

   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.expected_words.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, bit [14:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_phase(bit [14:0] thr_data, bit [14:0] half, int stall, int gap);
      settle();
      write_csr(CSR_THRESHOLD, thr_data);
      write_csr(CSR_HALF, half);
      stall_level = stall;
      gap_max     = gap;
      burst_left  = 0;
   endtask

   task automatic random_items(int n);
      int stop;
      int roll;
      stop = items_sent + n;
      while (items_sent < stop) begin
         roll = $urandom_range(0, 19);
         if (roll < 6) begin
            send_tick();
         end else begin
            if (roll < 12) begin
               load_frame({SLAVE_ID, FUNC_READ, BCNT_PWR,
                           pick_byte(), pick_byte(), pick_byte(), pick_byte()}, 7);
            end else begin
               load_frame({SLAVE_ID, FUNC_READ, BCNT_SOC, pick_byte(), pick_byte()}, 5);
            end
            repeat ($urandom_range(0, 5) == 0 ? $urandom_range(3, 12) : 2) begin
               frame_q.push_back(8'($urandom));
            end
            if (roll >= 16) begin
               break_frame();
            end
            send_frame(10);
         end
      end
   endtask

   initial begin
      sb = new();
      req_bus.valid   = 1'b0;
      req_bus.kind    = 1'b0;
      req_bus.rx_byte = 8'h00;
      req_bus.rx_last = 1'b0;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = CSR_THRESHOLD;
      csr_bus.data    = '0;
      rsp_bus.ready   = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed: reset settings, both requests, tick inside a frame,
      // current/capacity extremes, SOC update, one-byte frame
      send_tick();
      set_phase(15'd50, 15'd2, 1, 3);
      send_ticks(4);
      send_word(1'b1, SLAVE_ID, 1'b0);
      send_word(1'b1, FUNC_READ, 1'b0);
      send_tick();
      load_frame({BCNT_SOC, 8'h00, 8'h1E, 8'($urandom), 8'($urandom)}, 5);
      send_frame(0);
      load_frame({SLAVE_ID, FUNC_READ, BCNT_PWR, 8'h80, 8'h00, 8'hFF, 8'hFF,
                  8'($urandom), 8'($urandom)}, 9);
      send_frame(0);
      load_frame({SLAVE_ID}, 1);
      send_frame(0);

      // random traffic under several register settings
      set_phase(15'd0, 15'd1, 0, 0);
      random_items(85);
      set_phase(15'd100, 15'd3, 2, 8);
      random_items(85);
      set_phase(15'h7FFF, 15'($urandom_range(5, 12)), 1, 4);
      random_items(85);
      set_phase(15'($urandom), 15'($urandom_range(13, 40)), $urandom_range(0, 2),
                $urandom_range(0, 6));
      random_items(85);

      // half period lowered below the count: no request without a wrap
      set_phase(15'd20, 15'd100, 1, 0);
      send_ticks(10);
      set_phase(15'd20, 15'd2, 0, 0);
      send_ticks(10);

      settle();
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

>>> sim.f
rtl/mbp_pkg.sv
rtl/mbp_ifs.sv
rtl/mbp_front.sv
rtl/mbp_queue.sv
rtl/mbp_back.sv
rtl/modbus_battery_poller_unit.sv
dv/modbus_battery_poller_unit_test.sv
